// File: design/text_cell_glyph_renderer_unit_defines.svh
// ----------------------------------------------------------------------------
// Text cell glyph renderer assertion macros
// Shared property forms for the renderer checks.
// ----------------------------------------------------------------------------
`ifndef TEXT_CELL_GLYPH_RENDERER_UNIT_DEFINES_SVH
`define TEXT_CELL_GLYPH_RENDERER_UNIT_DEFINES_SVH

// Same-cycle implication, off during reset.
`define TCGR_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("renderer check failed");

// Next-cycle implication, off during reset.
`define TCGR_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("renderer check failed");

`endif

// File: design/tcgr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text cell glyph renderer package
// Font geometry, command codes and divider interface types.
// ----------------------------------------------------------------------------
package tcgr_pkg;

  localparam int GLYPH_WIDTH  = 8;
  localparam int GLYPH_HEIGHT = 16;
  localparam int GLYPH_COUNT  = 96;
  localparam int ROW_SLOTS    = 16;
  localparam int FIRST_CODE   = 32;
  localparam int PIXEL_BYTES  = 4;

  localparam int ROW_W    = $clog2(ROW_SLOTS);
  localparam int GLYPH_W  = 7;
  localparam int FONT_DEPTH = GLYPH_COUNT * ROW_SLOTS;
  localparam int FONT_AW  = GLYPH_W + ROW_W;
  localparam int DIV_W    = 16;
  localparam int DIV_CNT_W = $clog2(DIV_W);
  localparam int OFF_W    = 26;

  localparam logic [15:0] WIDTH_MASK = 16'((32'd1 << GLYPH_WIDTH) - 32'd1);

  localparam logic [1:0] CMD_DRAW   = 2'd0;
  localparam logic [1:0] CMD_CURSOR = 2'd1;
  localparam logic [1:0] CMD_LOAD   = 2'd2;

  localparam logic [1:0] REG_SCREEN_WIDTH = 2'd0;
  localparam logic [1:0] REG_TEXT_COLUMNS = 2'd1;
  localparam logic [1:0] REG_TEXT_CELLS   = 2'd2;
  localparam logic [1:0] REG_CURSOR_CODE  = 2'd3;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [DIV_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quot;
    logic [DIV_W-1:0] rem;
  } div_rsp_t;

endpackage

// File: design/text_cell_glyph_renderer_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text cell glyph renderer
// Draws bitmap font glyphs as framebuffer row offsets and row pixel bits.
// ----------------------------------------------------------------------------
// A draw or cursor item runs the shared one-bit-per-cycle divider twice
// (cell index modulo cell count, then row and column split), one multiply
// and one add form the base offset, and then one font read and one result
// per cycle for the 16 glyph rows while out_ready stays high. A code
// without a glyph goes to an error state and gives a single error result
// from the output register once that register is free. A font load item
// writes one font row and gives no result. in_ready is high only while
// the sequencer is idle.
`include "text_cell_glyph_renderer_unit_defines.svh"

module text_cell_glyph_renderer_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        wr_en,
  input  logic [1:0]  wr_index,
  input  logic [15:0] wr_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  cmd,
  input  logic [15:0] cell_index,
  input  logic [7:0]  char_code,
  input  logic [6:0]  load_glyph,
  input  logic [3:0]  load_row,
  input  logic [15:0] load_bits,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [25:0] row_offset,
  output logic [15:0] row_bits,
  output logic        is_last,
  output logic        bad_code
);
  import tcgr_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DIV1 = 3'd1;
  localparam logic [2:0] S_DIV2 = 3'd2;
  localparam logic [2:0] S_MUL  = 3'd3;
  localparam logic [2:0] S_BASE = 3'd4;
  localparam logic [2:0] S_ROW  = 3'd5;
  localparam logic [2:0] S_BAD  = 3'd6;

  logic [12:0] screen_width;
  logic [9:0]  text_columns;
  logic [15:0] text_cells;
  logic [7:0]  cursor_code;

  logic [2:0]         state;
  logic [2:0]         state_next;
  logic [GLYPH_W-1:0] glyph;
  logic [ROW_W-1:0]   cy;
  logic [ROW_W-1:0]   cy_next;
  logic [19:0]        py;
  logic [9:0]         col_idx;
  logic [23:0]        prod;
  logic [OFF_W-1:0]   offset;

  logic               accept;
  logic               draw_go;
  logic [7:0]         code;
  logic               code_bad;
  logic [7:0]         glyph_code;
  logic               slot_free;
  logic               emit_row;
  logic [15:0]        cells_nz;
  logic [15:0]        cols_nz;
  logic [32:0]        prod_full;
  logic [OFF_W-1:0]   stride;
  logic [15:0]        rd_data;
  logic               load_go;

  div_req_t div_req;
  div_rsp_t div_rsp;

  assign accept    = in_valid && in_ready;
  assign in_ready  = (state == S_IDLE);
  assign slot_free = !out_valid || out_ready;
  assign code       = (cmd == CMD_CURSOR) ? cursor_code : char_code;
  assign glyph_code = code - 8'(FIRST_CODE);
  assign code_bad   = (code < 8'(FIRST_CODE)) || (glyph_code >= 8'(GLYPH_COUNT));
  assign draw_go    = accept && ((cmd == CMD_DRAW) || (cmd == CMD_CURSOR));
  assign load_go    = accept && (cmd == CMD_LOAD) && (load_glyph < GLYPH_W'(GLYPH_COUNT));
  assign cells_nz   = (text_cells == '0) ? 16'd1 : text_cells;
  assign cols_nz    = (text_columns == '0) ? 16'd1 : {6'd0, text_columns};
  assign prod_full  = {13'd0, py} * {20'd0, screen_width};
  assign stride     = OFF_W'({screen_width, 2'b00});
  assign emit_row   = (state == S_ROW) && slot_free;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width <= 13'd1024;
      text_columns <= 10'd128;
      text_cells   <= 16'd6144;
      cursor_code  <= 8'd95;
    end else if (wr_en) begin
      case (wr_index)
        REG_SCREEN_WIDTH: screen_width <= wr_data[12:0];
        REG_TEXT_COLUMNS: text_columns <= wr_data[9:0];
        REG_TEXT_CELLS:   text_cells   <= wr_data;
        REG_CURSOR_CODE:  cursor_code  <= wr_data[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    div_req.start    = (draw_go && !code_bad) || ((state == S_DIV1) && div_rsp.done);
    div_req.dividend = (state == S_DIV1) ? div_rsp.rem : cell_index;
    div_req.divisor  = (state == S_DIV1) ? cols_nz : cells_nz;
  end

  tcgr_divider u_divider (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  tcgr_font_mem u_font_mem (
    .clk     (clk),
    .wr_en   (load_go),
    .wr_addr ({load_glyph, load_row}),
    .wr_data (load_bits),
    .rd_addr ({glyph, cy_next}),
    .rd_data (rd_data)
  );

  // Sequencer
  always_comb begin
    state_next = state;
    cy_next    = cy;
    case (state)
      S_IDLE: begin
        if (draw_go) begin
          state_next = code_bad ? S_BAD : S_DIV1;
        end
      end
      S_DIV1: begin
        if (div_rsp.done) begin
          state_next = S_DIV2;
        end
      end
      S_DIV2: begin
        if (div_rsp.done) begin
          state_next = S_MUL;
        end
      end
      S_MUL: begin
        state_next = S_BASE;
      end
      S_BASE: begin
        state_next = S_ROW;
        cy_next    = '0;
      end
      S_ROW: begin
        if (slot_free) begin
          if (cy == ROW_W'(GLYPH_HEIGHT - 1)) begin
            state_next = S_IDLE;
          end else begin
            cy_next = cy + 1'b1;
          end
        end
      end
      S_BAD: begin
        if (slot_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cy    <= '0;
    end else begin
      state <= state_next;
      cy    <= cy_next;
    end
  end

  always_ff @(posedge clk) begin
    if (draw_go) begin
      glyph <= glyph_code[GLYPH_W-1:0];
    end
    if ((state == S_DIV2) && div_rsp.done) begin
      py      <= 20'(div_rsp.quot * GLYPH_HEIGHT);
      col_idx <= div_rsp.rem[9:0];
    end
    if (state == S_MUL) begin
      prod <= prod_full[23:0];
    end
    if (state == S_BASE) begin
      offset <= OFF_W'({prod, 2'b00}) + OFF_W'(col_idx * (GLYPH_WIDTH * PIXEL_BYTES));
    end else if (emit_row) begin
      offset <= offset + stride;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == S_BAD) && slot_free) begin
      out_valid <= 1'b1;
    end else if (emit_row) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_BAD) && slot_free) begin
      row_offset <= '0;
      row_bits   <= '0;
      is_last    <= 1'b1;
      bad_code   <= 1'b1;
    end else if (emit_row) begin
      row_offset <= offset;
      row_bits   <= rd_data & WIDTH_MASK;
      is_last    <= (cy == ROW_W'(GLYPH_HEIGHT - 1));
      bad_code   <= 1'b0;
    end
  end

  `TCGR_ASSERT_NOW(a_bad_is_last, clk, rst, out_valid && bad_code, is_last && (row_bits == '0))
  `TCGR_ASSERT_NOW(a_bits_masked, clk, rst, out_valid, (row_bits & ~WIDTH_MASK) == '0)
  `TCGR_ASSERT_NOW(a_div_done_owner, clk, rst, div_rsp.done, (state == S_DIV1) || (state == S_DIV2))
  `TCGR_ASSERT_NEXT(a_last_row_idle, clk, rst, emit_row && (cy == ROW_W'(GLYPH_HEIGHT - 1)), in_ready)

endmodule

// File: design/tcgr_divider.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text cell glyph renderer divider
// Restoring divider, one quotient bit per cycle, shared by both cell splits.
// ----------------------------------------------------------------------------
module tcgr_divider (
  input  logic               clk,
  input  logic               rst,
  input  tcgr_pkg::div_req_t req,
  output tcgr_pkg::div_rsp_t rsp
);
  import tcgr_pkg::*;

  logic                 busy;
  logic                 done;
  logic [DIV_CNT_W-1:0] cnt;
  logic [DIV_W-1:0]     quot;
  logic [DIV_W-1:0]     rem;
  logic [DIV_W-1:0]     divisor;
  logic [DIV_W:0]       shifted;
  logic [DIV_W:0]       diff;

  assign shifted = {rem, quot[DIV_W-1]};
  assign diff    = shifted - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == DIV_CNT_W'(DIV_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      quot    <= req.dividend;
      rem     <= '0;
      divisor <= req.divisor;
    end else if (busy) begin
      if (!diff[DIV_W]) begin
        rem  <= diff[DIV_W-1:0];
        quot <= {quot[DIV_W-2:0], 1'b1};
      end else begin
        rem  <= shifted[DIV_W-1:0];
        quot <= {quot[DIV_W-2:0], 1'b0};
      end
    end
  end

  assign rsp.done = done;
  assign rsp.quot = quot;
  assign rsp.rem  = rem;

endmodule

// File: design/tcgr_font_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text cell glyph renderer font memory
// One row pattern per entry, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module tcgr_font_mem (
  input  logic                   clk,
  input  logic                   wr_en,
  input  logic [tcgr_pkg::FONT_AW-1:0] wr_addr,
  input  logic [15:0]            wr_data,
  input  logic [tcgr_pkg::FONT_AW-1:0] rd_addr,
  output logic [15:0]            rd_data
);
  import tcgr_pkg::*;

  logic [15:0] mem [FONT_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

// File: dv/text_cell_glyph_renderer_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text cell glyph renderer unit test
// Fills the font memory, draws characters and cursors under several screen
// settings, and checks every emitted glyph row against an in-bench predictor.
// ----------------------------------------------------------------------------
module text_cell_glyph_renderer_unit_test;
  import tcgr_pkg::*;

  localparam logic [1:0] CMD_UNUSED  = 2'd3;
  localparam int         DRAIN_CYCLES = 70;
  localparam int         CYCLE_LIMIT  = 900000;

  typedef struct packed {
    logic [25:0] offset;
    logic [15:0] bits;
    logic        last;
    logic        bad;
  } glyph_row_t;

  logic        clk        = 1'b0;
  logic        rst        = 1'b1;
  logic        wr_en      = 1'b0;
  logic [1:0]  wr_index   = REG_SCREEN_WIDTH;
  logic [15:0] wr_data    = '0;
  logic        in_valid   = 1'b0;
  logic        in_ready;
  logic [1:0]  cmd        = CMD_DRAW;
  logic [15:0] cell_index = '0;
  logic [7:0]  char_code  = '0;
  logic [6:0]  load_glyph = '0;
  logic [3:0]  load_row   = '0;
  logic [15:0] load_bits  = '0;
  logic        out_valid;
  logic        out_ready  = 1'b0;
  logic [25:0] row_offset;
  logic [15:0] row_bits;
  logic        is_last;
  logic        bad_code;

  glyph_row_t              glyph_rows_due[$];
  glyph_row_t              row_want;
  logic [15:0]             font_copy[FONT_DEPTH];
  logic [ROW_SLOTS-1:0]    rows_loaded[GLYPH_COUNT];
  int                      ready_glyphs[$];
  logic [12:0]             scr_width;
  logic [9:0]              txt_cols;
  logic [15:0]             txt_cells;
  logic [7:0]              cur_code;
  int                      mismatch_count  = 0;
  int                      rows_checked    = 0;
  int                      draws_sent      = 0;
  int                      transfers_in    = 0;
  int                      setting_changes = 0;
  int                      cycle_count     = 0;
  int                      out_stall       = 0;
  bit                      idle_on         = 1'b1;

  always #5 clk = ~clk;

  text_cell_glyph_renderer_unit dut (
    .clk        (clk),
    .rst        (rst),
    .wr_en      (wr_en),
    .wr_index   (wr_index),
    .wr_data    (wr_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .cmd        (cmd),
    .cell_index (cell_index),
    .char_code  (char_code),
    .load_glyph (load_glyph),
    .load_row   (load_row),
    .load_bits  (load_bits),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .row_offset (row_offset),
    .row_bits   (row_bits),
    .is_last    (is_last),
    .bad_code   (bad_code)
  );

  function automatic logic [7:0] pick_bad_code();
    if ($urandom_range(0, 1) == 0) begin
      return 8'($urandom_range(0, FIRST_CODE - 1));
    end
    return 8'($urandom_range(FIRST_CODE + GLYPH_COUNT, 255));
  endfunction

  function automatic logic [7:0] pick_glyph_code();
    return 8'(ready_glyphs[$urandom_range(0, ready_glyphs.size() - 1)] + FIRST_CODE);
  endfunction

  task automatic predict_glyph_rows(input logic [15:0] cell_pos, input logic [7:0] code);
    int unsigned     cells, cols, idx, px, py, glyph;
    longint unsigned off;
    glyph_row_t      r;
    draws_sent++;
    if (code < FIRST_CODE || code >= FIRST_CODE + GLYPH_COUNT) begin
      r = '0;
      r.last = 1'b1;
      r.bad = 1'b1;
      glyph_rows_due.push_back(r);
    end else begin
      glyph = code - FIRST_CODE;
      cells = (txt_cells == 0) ? 1 : txt_cells;
      cols = (txt_cols == 0) ? 1 : txt_cols;
      idx = cell_pos % cells;
      py = (idx / cols) * GLYPH_HEIGHT;
      px = (idx % cols) * GLYPH_WIDTH;
      for (int cy = 0; cy < GLYPH_HEIGHT; cy++) begin
        off = longint'(PIXEL_BYTES) * px
            + longint'(PIXEL_BYTES) * longint'(py + cy) * longint'(scr_width);
        r.offset = off[25:0];
        r.bits = font_copy[glyph * ROW_SLOTS + cy] & WIDTH_MASK;
        r.last = (cy == GLYPH_HEIGHT - 1);
        r.bad = 1'b0;
        glyph_rows_due.push_back(r);
      end
    end
  endtask

  task automatic send_item(input logic [1:0] c, input logic [15:0] cell_pos,
                           input logic [7:0] code, input logic [6:0] lg,
                           input logic [3:0] lr, input logic [15:0] lb);
    int gap;
    gap = (idle_on && $urandom_range(0, 4) == 0) ? $urandom_range(1, 11) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    cmd        <= c;
    cell_index <= cell_pos;
    char_code  <= code;
    load_glyph <= lg;
    load_row   <= lr;
    load_bits  <= lb;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    transfers_in++;
    case (c)
      CMD_DRAW: begin
        predict_glyph_rows(cell_pos, code);
      end
      CMD_CURSOR: begin
        predict_glyph_rows(cell_pos, cur_code);
      end
      CMD_LOAD: begin
        if (lg < GLYPH_COUNT) begin
          font_copy[lg * ROW_SLOTS + lr] = lb;
          if (rows_loaded[lg] != '1) begin
            rows_loaded[lg] = rows_loaded[lg] | (ROW_SLOTS'(1) << lr);
            if (rows_loaded[lg] == '1) ready_glyphs.push_back(lg);
          end
        end
      end
      default: ;
    endcase
  endtask

  task automatic go_quiet();
    in_valid <= 1'b0;
    while (glyph_rows_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_screen(input logic [15:0] w, input logic [15:0] cols,
                            input logic [15:0] cells, input logic [15:0] cur);
    go_quiet();
    wr_en    <= 1'b1;
    wr_index <= REG_SCREEN_WIDTH;
    wr_data  <= w;
    @(posedge clk);
    wr_index <= REG_TEXT_COLUMNS;
    wr_data  <= cols;
    @(posedge clk);
    wr_index <= REG_TEXT_CELLS;
    wr_data  <= cells;
    @(posedge clk);
    wr_index <= REG_CURSOR_CODE;
    wr_data  <= cur;
    @(posedge clk);
    wr_en <= 1'b0;
    scr_width = w[12:0];
    txt_cols = cols[9:0];
    txt_cells = cells;
    cur_code = cur[7:0];
    setting_changes++;
  endtask

  task automatic test_error_codes();
    send_item(CMD_DRAW, 16'h0000, 8'd0, 7'd0, 4'd0, 16'h0000);
    send_item(CMD_DRAW, 16'hffff, 8'd31, 7'h7f, 4'hf, 16'hffff);
    send_item(CMD_DRAW, 16'h1234, 8'd128, 7'd5, 4'd3, 16'h5a5a);
    send_item(CMD_DRAW, 16'h8000, 8'd255, 7'd0, 4'd0, 16'h0000);
    send_item(CMD_LOAD, 16'h0000, 8'd0, 7'(GLYPH_COUNT), 4'd0, 16'hffff);
    send_item(CMD_LOAD, 16'hffff, 8'hff, 7'h7f, 4'hf, 16'hffff);
    send_item(CMD_UNUSED, 16'hffff, 8'd65, 7'd1, 4'd1, 16'hffff);
  endtask

  task automatic test_font_extremes();
    for (int row = 0; row < GLYPH_HEIGHT; row++) begin
      send_item(CMD_LOAD, 16'h0000, 8'd0, 7'd0, 4'(row), (row % 2) ? 16'h0000 : 16'hffff);
      send_item(CMD_LOAD, 16'hffff, 8'hff, 7'd63, 4'(row), 16'h0001 << row);
      send_item(CMD_LOAD, 16'h0000, 8'd0, 7'(GLYPH_COUNT - 1), 4'(row),
                ~(16'h0001 << row));
    end
    send_item(CMD_DRAW, 16'd0, 8'(FIRST_CODE), 7'd0, 4'd0, 16'h0000);
    send_item(CMD_DRAW, 16'hffff, 8'(FIRST_CODE + GLYPH_COUNT - 1), 7'h7f, 4'hf, 16'hffff);
    send_item(CMD_DRAW, 16'd127, 8'd95, 7'd0, 4'd0, 16'h0000);
    send_item(CMD_DRAW, 16'd6144, 8'd95, 7'd0, 4'd0, 16'h0000);
    send_item(CMD_CURSOR, 16'd6143, 8'd0, 7'd0, 4'd0, 16'h0000);
  endtask

  task automatic test_register_extremes();
    set_screen(16'd1, 16'd1, 16'd1, 16'(FIRST_CODE));
    send_item(CMD_DRAW, 16'hffff, 8'd127, 7'd0, 4'd0, 16'h0000);
    send_item(CMD_CURSOR, 16'd7, 8'd255, 7'd0, 4'd0, 16'h0000);
    set_screen(16'd4096, 16'd512, 16'd65535, 16'd127);
    send_item(CMD_DRAW, 16'd65534, 8'd32, 7'd0, 4'd0, 16'h0000);
    send_item(CMD_CURSOR, 16'hffff, 8'd0, 7'd0, 4'd0, 16'h0000);
    set_screen(16'd0, 16'd0, 16'd0, 16'd0);
    send_item(CMD_DRAW, 16'd1234, 8'd95, 7'd0, 4'd0, 16'h0000);
    send_item(CMD_CURSOR, 16'd99, 8'd95, 7'd0, 4'd0, 16'h0000);
    set_screen(16'hffff, 16'h0001, 16'hffff, 16'h00ff);
    send_item(CMD_DRAW, 16'd65534, 8'd127, 7'd0, 4'd0, 16'h0000);
    send_item(CMD_CURSOR, 16'd3, 8'd32, 7'd0, 4'd0, 16'h0000);
    set_screen(16'hffff, 16'hffff, 16'hffff, 16'd95);
    send_item(CMD_DRAW, 16'hfffe, 8'd32, 7'd0, 4'd0, 16'h0000);
    send_item(CMD_CURSOR, 16'h7fff, 8'd0, 7'd0, 4'd0, 16'h0000);
  endtask

  task automatic test_random_traffic();
    int         rows_order[ROW_SLOTS];
    int         counted, sel, j, tmp;
    logic [6:0] glyph_pick;
    logic [7:0] code_pick;
    logic [15:0] cell_pick;
    for (int phase = 0; phase < 5; phase++) begin
      idle_on = (phase < 4) && (phase != 2);
      set_screen(($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 16'hffff))
                                             : 16'($urandom_range(1, 4096)),
                 ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 16'hffff))
                                             : 16'($urandom_range(1, 512)),
                 ($urandom_range(0, 1) == 0) ? 16'($urandom_range(1, 4096))
                                             : 16'($urandom_range(0, 16'hffff)),
                 ($urandom_range(0, 3) == 0) ? 16'(pick_bad_code())
                                             : 16'(pick_glyph_code()));
      counted = 0;
      while (counted < 80) begin
        sel = $urandom_range(0, 99);
        if (sel < 10) begin
          glyph_pick = 7'($urandom_range(0, GLYPH_COUNT - 1));
          for (int i = 0; i < ROW_SLOTS; i++) rows_order[i] = i;
          for (int i = ROW_SLOTS - 1; i > 0; i--) begin
            j = $urandom_range(0, i);
            tmp = rows_order[i];
            rows_order[i] = rows_order[j];
            rows_order[j] = tmp;
          end
          for (int i = 0; i < ROW_SLOTS; i++) begin
            send_item(CMD_LOAD, 16'($urandom_range(0, 16'hffff)), 8'($urandom_range(0, 255)),
                      glyph_pick, 4'(rows_order[i]), 16'($urandom_range(0, 16'hffff)));
          end
          counted += ROW_SLOTS;
        end else if (sel < 18) begin
          glyph_pick = 7'($urandom_range(0, 127));
          send_item(CMD_LOAD, 16'($urandom_range(0, 16'hffff)), 8'($urandom_range(0, 255)),
                    glyph_pick, 4'($urandom_range(0, 15)), 16'($urandom_range(0, 16'hffff)));
          if (glyph_pick < GLYPH_COUNT) counted++;
        end else if (sel < 93) begin
          code_pick = ($urandom_range(0, 5) == 0) ? pick_bad_code() : pick_glyph_code();
          case ($urandom_range(0, 9))
            0: cell_pick = 16'h0000;
            1: cell_pick = 16'hffff;
            default: cell_pick = 16'($urandom_range(0, 16'hffff));
          endcase
          send_item((sel < 65) ? CMD_DRAW : CMD_CURSOR, cell_pick, code_pick,
                    7'($urandom_range(0, 127)), 4'($urandom_range(0, 15)),
                    16'($urandom_range(0, 16'hffff)));
          counted++;
        end else begin
          send_item(CMD_UNUSED, 16'($urandom_range(0, 16'hffff)), 8'($urandom_range(0, 255)),
                    7'($urandom_range(0, 127)), 4'($urandom_range(0, 15)),
                    16'($urandom_range(0, 16'hffff)));
        end
      end
    end
  endtask

  function automatic void compare_field(input string name, input logic [25:0] want,
                                        input logic [25:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk) begin
    if (out_stall > 0) begin
      out_ready <= 1'b0;
      out_stall = out_stall - 1;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      out_ready <= 1'b0;
      out_stall = $urandom_range(0, 10);
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (glyph_rows_due.size() == 0) begin
        $display("%0t: row with none expected, offset %0h bits %0h last %0b bad %0b",
                 $time, row_offset, row_bits, is_last, bad_code);
        mismatch_count++;
      end else begin
        row_want = glyph_rows_due.pop_front();
        compare_field("row_offset", row_want.offset, row_offset);
        compare_field("row_bits", 26'(row_want.bits), 26'(row_bits));
        compare_field("is_last", 26'(row_want.last), 26'(is_last));
        compare_field("bad_code", 26'(row_want.bad), 26'(bad_code));
        rows_checked++;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d rows still due", cycle_count,
               glyph_rows_due.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    scr_width = 13'd1024;
    txt_cols = 10'd128;
    txt_cells = 16'd6144;
    cur_code = 8'd95;
    foreach (rows_loaded[g]) rows_loaded[g] = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    test_error_codes();
    test_font_extremes();
    test_register_extremes();
    test_random_traffic();
    go_quiet();
    $display("covered %0d input transfers, %0d draws and cursors, %0d rows checked",
             transfers_in, draws_sent, rows_checked);
    $display("across %0d screen settings with %0d glyphs fully loaded",
             setting_changes, ready_glyphs.size());
    if (mismatch_count == 0 && glyph_rows_due.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("%0d mismatches, %0d rows never arrived", mismatch_count,
               glyph_rows_due.size());
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
